>>> hdl/csfrm_pkg.sv
// ----------------------------------------------------------------------------
// csfrm_pkg: shared constants for the channel sweep frame rate monitor
// Channel count, field widths, request and register codes, reset values.
// ----------------------------------------------------------------------------
package csfrm_pkg;

   localparam int NUM_CHANNELS = 13;
   localparam int COUNT_BITS   = 16;

   // Channel index width; one bit at least so a single channel still works.
   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int CHAN_FIELD_W = 4;
   localparam int TIME_W       = 32;
   localparam int MS_W         = 16;
   localparam int RATE_W       = 20;
   localparam int REQ_W        = 3;

   // Rate scale: frames per millisecond window to Q.4 frames per second.
   localparam int SCALE        = 16000;
   localparam int SCALE_W      = 14;
   localparam int NUM_W        = COUNT_BITS + SCALE_W;
   localparam int STEP_W       = $clog2(NUM_W + 1);

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   localparam int ENTRY_W = 3 * RATE_W;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_FRAME = 3'd1;
   localparam logic [REQ_W-1:0] REQ_START = 3'd2;
   localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;

   // Register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME   = 2'd2;

   localparam logic [MS_W-1:0]         SETTLE_RESET = 16'd100;
   localparam logic [MS_W-1:0]         DWELL_RESET  = 16'd500;
   localparam logic [CHAN_FIELD_W-1:0] HOME_RESET   = 4'd6;

   // Channel number shown to the outside: index plus one, kept to four bits.
   function automatic logic [CHAN_FIELD_W-1:0] chan_number(input logic [CH_W-1:0] idx);
      logic [CHAN_FIELD_W:0] sum;
      sum = (CHAN_FIELD_W + 1)'(idx) + (CHAN_FIELD_W + 1)'(1);
      return sum[CHAN_FIELD_W-1:0];
   endfunction

endpackage

>>> hdl/channel_sweep_frame_rate_monitor.sv
// ----------------------------------------------------------------------------
// channel_sweep_frame_rate_monitor
// Sweeps radio channels, counts frames after each hop has settled and keeps
// the last, peak and last nonzero frame rate of every channel.
// ----------------------------------------------------------------------------
// A transaction that commits a channel rate (a tick past the dwell time while
// the sweep runs) passes through the bit-serial divider, which produces one
// quotient bit per cycle over COUNT_BITS + 14 bits; every other transaction
// skips it. No new request is taken until the last one is through.
// Reset (synchronous, active high) stops the sweep, clears the statistics
// through per-channel valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module channel_sweep_frame_rate_monitor (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [csfrm_pkg::REQ_W-1:0]            req_type,
   input  logic [csfrm_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [csfrm_pkg::CHAN_FIELD_W-1:0]     req_query_channel,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [csfrm_pkg::CHAN_FIELD_W-1:0]     rsp_current_channel,
   output logic                                   rsp_sweep_running,
   output logic                                   rsp_settling,
   output logic                                   rsp_tune_valid,
   output logic [csfrm_pkg::CHAN_FIELD_W-1:0]     rsp_tune_channel,
   output logic [csfrm_pkg::RATE_W-1:0]           rsp_query_rate,
   output logic [csfrm_pkg::RATE_W-1:0]           rsp_query_peak,
   output logic [csfrm_pkg::RATE_W-1:0]           rsp_query_last_nonzero,

   input  logic                                   csr_we,
   input  logic [csfrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [csfrm_pkg::MS_W-1:0]             csr_wdata
);

   localparam int CH_W   = csfrm_pkg::CH_W;
   localparam int NUM_W  = csfrm_pkg::NUM_W;
   localparam int STEP_W = csfrm_pkg::STEP_W;
   localparam int MS_W   = csfrm_pkg::MS_W;
   localparam int TIME_W = csfrm_pkg::TIME_W;
   localparam int RATE_W = csfrm_pkg::RATE_W;
   localparam int CF_W   = csfrm_pkg::CHAN_FIELD_W;
   localparam int NCH    = csfrm_pkg::NUM_CHANNELS;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_QUERY  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                   state_ff, state_in;

   // Configuration registers.
   logic [MS_W-1:0]              settle_ff;
   logic [MS_W-1:0]              dwell_ff;
   logic [CF_W-1:0]              home_ff;

   // The transaction being worked on.
   logic [csfrm_pkg::REQ_W-1:0]  type_ff, type_in;
   logic [TIME_W-1:0]            now_ff, now_in;
   logic [CF_W-1:0]              qch_ff, qch_in;

   // Sweep state.
   logic                         running_ff, running_in;
   logic [CH_W-1:0]              chan_ff, chan_in;
   logic [TIME_W-1:0]            hop_ff, hop_in;
   logic [csfrm_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [NCH-1:0]               valid_ff, valid_in;

   logic                         tune_valid_ff, tune_valid_in;
   logic [CF_W-1:0]              tune_chan_ff, tune_chan_in;

   // Bit-serial divider: the quotient shifts in while the numerator shifts out.
   logic [MS_W-1:0]              win_ff, win_in;
   logic [MS_W-1:0]              rem_ff, rem_in;
   logic [NUM_W-1:0]             quo_ff, quo_in;
   logic [STEP_W-1:0]            step_ff, step_in;

   // Statistics memory: rate, peak and last nonzero value of each channel.
   logic [csfrm_pkg::ENTRY_W-1:0] stats_mem_ff [NCH];
   logic [csfrm_pkg::ENTRY_W-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic [CH_W-1:0]               rd_addr;
   logic                          rd_enable;
   logic                          mem_we;
   logic [csfrm_pkg::ENTRY_W-1:0] mem_wdata;

   // Response register.
   logic                         rsp_valid_ff;
   logic [CF_W-1:0]              rsp_cur_ff;
   logic                         rsp_run_ff;
   logic                         rsp_settle_ff;
   logic                         rsp_tv_ff;
   logic [CF_W-1:0]              rsp_tc_ff;
   logic [RATE_W-1:0]            rsp_rate_ff;
   logic [RATE_W-1:0]            rsp_peak_ff;
   logic [RATE_W-1:0]            rsp_last_ff;

   logic                         accept;
   logic                         rsp_load;
   logic [TIME_W-1:0]            elapsed;
   logic                         q_in_range;
   logic [CF_W-1:0]              qch_minus1;
   logic [MS_W:0]                trial;
   logic                         trial_ge;
   logic [RATE_W-1:0]            rate;
   logic [RATE_W-1:0]            old_peak;
   logic [RATE_W-1:0]            old_last;
   logic [CH_W-1:0]              chan_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Wrapping time since the last hop, against the current hop stamp.
   assign elapsed = now_ff - hop_ff;

   assign q_in_range = (qch_ff != '0) &&
                       ({1'b0, qch_ff} <= (CF_W + 1)'(NCH));
   assign qch_minus1 = qch_ff - CF_W'(1);

   // The query address is held through the response wait so the read data
   // stays put; otherwise the memory looks at the channel being dwelt on.
   always_comb begin
      if ((state_ff == ST_QUERY) || (state_ff == ST_FINISH)) begin
         rd_addr   = q_in_range ? qch_minus1[CH_W-1:0] : '0;
         rd_enable = q_in_range;
      end else begin
         rd_addr   = chan_ff;
         rd_enable = 1'b1;
      end
   end

   // One restoring division step per cycle.
   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, win_ff});

   // Committed rate, saturated to full scale. An empty window gives full scale if any frame counted.
   always_comb begin
      if (win_ff == '0) begin
         rate = (count_ff != '0) ? csfrm_pkg::RATE_MAX : '0;
      end else if (|quo_ff[NUM_W-1:RATE_W]) begin
         rate = csfrm_pkg::RATE_MAX;
      end else begin
         rate = quo_ff[RATE_W-1:0];
      end
   end

   // Entries not written since the last start read as zero.
   assign old_peak = rd_valid_ff ? rd_data_ff[RATE_W +: RATE_W] : '0;
   assign old_last = rd_valid_ff ? rd_data_ff[0 +: RATE_W] : '0;

   assign chan_next = (chan_ff == CH_W'(NCH - 1)) ? '0 : chan_ff + CH_W'(1);

   assign mem_we    = (state_ff == ST_COMMIT);
   assign mem_wdata = {rate,
                       (rate > old_peak) ? rate : old_peak,
                       (rate != '0) ? rate : old_last};

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      now_in        = now_ff;
      qch_in        = qch_ff;
      running_in    = running_ff;
      chan_in       = chan_ff;
      hop_in        = hop_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      tune_valid_in = tune_valid_ff;
      tune_chan_in  = tune_chan_ff;
      win_in        = win_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_in       = req_type;
               now_in        = req_now_ms;
               qch_in        = req_query_channel;
               tune_valid_in = 1'b0;
               tune_chan_in  = '0;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_QUERY;
            case (type_ff)
               csfrm_pkg::REQ_TICK: begin
                  if (running_ff && (elapsed >= TIME_W'(dwell_ff))) begin
                     win_in   = (dwell_ff > settle_ff) ? dwell_ff - settle_ff : '0;
                     rem_in   = '0;
                     quo_in   = NUM_W'(count_ff) *
                                NUM_W'(csfrm_pkg::SCALE);
                     step_in  = STEP_W'(NUM_W);
                     state_in = ST_DIV;
                  end
               end
               csfrm_pkg::REQ_FRAME: begin
                  if (running_ff && (elapsed >= TIME_W'(settle_ff)) && !(&count_ff)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               csfrm_pkg::REQ_START: begin
                  running_in    = 1'b1;
                  valid_in      = '0;
                  chan_in       = '0;
                  count_in      = '0;
                  hop_in        = now_ff;
                  tune_valid_in = 1'b1;
                  tune_chan_in  = CF_W'(1);
               end
               csfrm_pkg::REQ_STOP: begin
                  running_in    = 1'b0;
                  tune_valid_in = 1'b1;
                  tune_chan_in  = home_ff;
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial[MS_W-1:0] - win_ff : trial[MS_W-1:0];
            quo_in  = {quo_ff[NUM_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            valid_in[chan_ff] = 1'b1;
            chan_in           = chan_next;
            count_in          = '0;
            hop_in            = now_ff;
            tune_valid_in     = 1'b1;
            tune_chan_in      = csfrm_pkg::chan_number(chan_next);
            state_in          = ST_QUERY;
         end
         ST_QUERY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= 1'b0;
         chan_ff       <= '0;
         hop_ff        <= '0;
         count_ff      <= '0;
         valid_ff      <= '0;
         tune_valid_ff <= 1'b0;
         tune_chan_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         chan_ff       <= chan_in;
         hop_ff        <= hop_in;
         count_ff      <= count_in;
         valid_ff      <= valid_in;
         tune_valid_ff <= tune_valid_in;
         tune_chan_ff  <= tune_chan_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      now_ff  <= now_in;
      qch_ff  <= qch_in;
      win_ff  <= win_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= csfrm_pkg::SETTLE_RESET;
         dwell_ff  <= csfrm_pkg::DWELL_RESET;
         home_ff   <= csfrm_pkg::HOME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            csfrm_pkg::CSR_SETTLE: settle_ff <= csr_wdata;
            csfrm_pkg::CSR_DWELL:  dwell_ff  <= csr_wdata;
            csfrm_pkg::CSR_HOME:   home_ff   <= csr_wdata[CF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stats_mem_ff[chan_ff] <= mem_wdata;
      end
      rd_data_ff  <= stats_mem_ff[rd_addr];
      rd_valid_ff <= rd_enable && valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The response reflects the state after the transaction; settling is
   // judged against the hop stamp as it now stands.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cur_ff    <= csfrm_pkg::chan_number(chan_ff);
         rsp_run_ff    <= running_ff;
         rsp_settle_ff <= running_ff && (elapsed < TIME_W'(settle_ff));
         rsp_tv_ff     <= tune_valid_ff;
         rsp_tc_ff     <= tune_chan_ff;
         rsp_rate_ff   <= rd_valid_ff ? rd_data_ff[2*RATE_W +: RATE_W] : '0;
         rsp_peak_ff   <= old_peak;
         rsp_last_ff   <= old_last;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_current_channel    = rsp_cur_ff;
   assign rsp_sweep_running      = rsp_run_ff;
   assign rsp_settling           = rsp_settle_ff;
   assign rsp_tune_valid         = rsp_tv_ff;
   assign rsp_tune_channel       = rsp_tc_ff;
   assign rsp_query_rate         = rsp_rate_ff;
   assign rsp_query_peak         = rsp_peak_ff;
   assign rsp_query_last_nonzero = rsp_last_ff;

endmodule

>>> tb/sv/channel_sweep_frame_rate_monitor_test.sv
// ----------------------------------------------------------------------------
// channel_sweep_frame_rate_monitor_test: self-checking bench for the sweep monitor
// Drives request transactions through the valid/ready input channel, keeps a
// behavioral copy of the sweep state and rate tables, and compares every
// result transaction field by field against the predicted report.
// ----------------------------------------------------------------------------
module channel_sweep_frame_rate_monitor_test;
   import csfrm_pkg::*;

   // The package names the four active request codes. Query only and the
   // three unused codes all just report, so the bench keeps its own name here.
   localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

   // Cycles to let pass after the last result before touching the registers.
   // A committing tick keeps the block busy longest, through the whole division.
   localparam int QUIET_CYCLES   = 48;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int WATCHDOG_UNITS = 4_000_000;

   // One predicted result transaction.
   typedef struct packed {
      logic [CHAN_FIELD_W-1:0] current_channel;
      logic                    sweep_running;
      logic                    settling;
      logic                    tune_valid;
      logic [CHAN_FIELD_W-1:0] tune_channel;
      logic [RATE_W-1:0]       query_rate;
      logic [RATE_W-1:0]       query_peak;
      logic [RATE_W-1:0]       query_last_nonzero;
   } sweep_report_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [REQ_W-1:0]        req_type;
   logic [TIME_W-1:0]       req_now_ms;
   logic [CHAN_FIELD_W-1:0] req_query_channel;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CHAN_FIELD_W-1:0] rsp_current_channel;
   logic                    rsp_sweep_running;
   logic                    rsp_settling;
   logic                    rsp_tune_valid;
   logic [CHAN_FIELD_W-1:0] rsp_tune_channel;
   logic [RATE_W-1:0]       rsp_query_rate;
   logic [RATE_W-1:0]       rsp_query_peak;
   logic [RATE_W-1:0]       rsp_query_last_nonzero;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [MS_W-1:0]         csr_wdata;

   channel_sweep_frame_rate_monitor DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_now_ms             (req_now_ms),
      .req_query_channel      (req_query_channel),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_current_channel    (rsp_current_channel),
      .rsp_sweep_running      (rsp_sweep_running),
      .rsp_settling           (rsp_settling),
      .rsp_tune_valid         (rsp_tune_valid),
      .rsp_tune_channel       (rsp_tune_channel),
      .rsp_query_rate         (rsp_query_rate),
      .rsp_query_peak         (rsp_query_peak),
      .rsp_query_last_nonzero (rsp_query_last_nonzero),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // Predicted sweep state. The register copies start at the reset defaults,
   // and the rate tables are cleared before the first transaction.
   logic [MS_W-1:0]         settle_cfg = SETTLE_RESET;
   logic [MS_W-1:0]         dwell_cfg  = DWELL_RESET;
   logic [CHAN_FIELD_W-1:0] home_cfg   = HOME_RESET;
   logic                    sweep_on   = 1'b0;
   int                      chan_idx   = 0;
   logic [TIME_W-1:0]       hop_ms     = '0;
   logic [COUNT_BITS-1:0]   frames_heard = '0;
   logic [RATE_W-1:0]       rate_log    [NUM_CHANNELS];
   logic [RATE_W-1:0]       peak_log    [NUM_CHANNELS];
   logic [RATE_W-1:0]       nonzero_log [NUM_CHANNELS];

   // Reports still owed by the block, oldest first.
   sweep_report_type expected_reports [$];
   sweep_report_type due_report;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int requests_sent      = 0;
   int reports_checked    = 0;
   int rates_committed    = 0;
   int mismatch_count     = 0;

   // Free-running clock with a period of two time units.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Every mismatch lands here: one line each, and every one is counted.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t, result %0d: %s", $time, reports_checked, what);
   endtask

   task automatic compare_field(input string name, input logic [RATE_W-1:0] got,
                                input logic [RATE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Applies one request to the predicted state and returns the report the
   // block owes for it. Elapsed time is a wrapping 32-bit difference.
   task automatic predict_sweep_step(input logic [REQ_W-1:0] kind,
                                     input logic [TIME_W-1:0] stamp,
                                     input logic [CHAN_FIELD_W-1:0] chan,
                                     output sweep_report_type rpt);
      logic [TIME_W-1:0] since_hop;
      logic [RATE_W-1:0] rate;
      logic [63:0]       frames_wide;
      logic [63:0]       window_ms;
      logic [63:0]       quotient;
      int                slot;
      rpt = '0;
      since_hop = stamp - hop_ms;
      case (kind)
         REQ_TICK: begin
            if (sweep_on && since_hop >= TIME_W'(dwell_cfg)) begin
               // An empty capture window reports full scale if anything at
               // all was heard, and zero otherwise.
               if (dwell_cfg <= settle_cfg) begin
                  rate = (frames_heard != '0) ? RATE_MAX : '0;
               end else begin
                  frames_wide = 64'(frames_heard);
                  window_ms = 64'(dwell_cfg - settle_cfg);
                  quotient = (frames_wide * SCALE) / window_ms;
                  rate = (quotient > RATE_MAX) ? RATE_MAX : quotient[RATE_W-1:0];
               end
               slot = chan_idx;
               rate_log[slot] = rate;
               if (rate > peak_log[slot]) peak_log[slot] = rate;
               if (rate != '0) nonzero_log[slot] = rate;
               chan_idx = (slot + 1) % NUM_CHANNELS;
               frames_heard = '0;
               hop_ms = stamp;
               rpt.tune_valid = 1'b1;
               rpt.tune_channel = CHAN_FIELD_W'(chan_idx + 1);
               rates_committed++;
            end
         end
         REQ_FRAME: begin
            if (sweep_on && since_hop >= TIME_W'(settle_cfg) &&
                frames_heard != {COUNT_BITS{1'b1}})
               frames_heard++;
         end
         REQ_START: begin
            foreach (rate_log[i]) begin
               rate_log[i] = '0;
               peak_log[i] = '0;
               nonzero_log[i] = '0;
            end
            sweep_on = 1'b1;
            chan_idx = 0;
            frames_heard = '0;
            hop_ms = stamp;
            rpt.tune_valid = 1'b1;
            rpt.tune_channel = CHAN_FIELD_W'(1);
         end
         REQ_STOP: begin
            sweep_on = 1'b0;
            rpt.tune_valid = 1'b1;
            rpt.tune_channel = home_cfg;
         end
         default: begin
         end
      endcase
      since_hop = stamp - hop_ms;
      rpt.current_channel = CHAN_FIELD_W'(chan_idx + 1);
      rpt.sweep_running = sweep_on;
      rpt.settling = sweep_on && (since_hop < TIME_W'(settle_cfg));
      if (chan >= 1 && chan <= NUM_CHANNELS) begin
         rpt.query_rate = rate_log[chan - 1];
         rpt.query_peak = peak_log[chan - 1];
         rpt.query_last_nonzero = nonzero_log[chan - 1];
      end
   endtask

   // Sends one request transaction. The sender may idle first; once valid is
   // up it holds with a steady payload until the block takes it. Valid is
   // left high on return so that back-to-back requests need no dead cycle.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] stamp,
                               input logic [CHAN_FIELD_W-1:0] chan);
      sweep_report_type rpt;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_now_ms = stamp;
      req_query_channel = chan;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_sweep_step(kind, stamp, chan, rpt);
      expected_reports.push_back(rpt);
      requests_sent++;
   endtask

   // Lowers valid and waits until every owed report has come back, then lets
   // the block finish whatever it is still doing.
   task automatic drain_results();
      int waited;
      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SETTLE: settle_cfg = value;
         CSR_DWELL:  dwell_cfg = value;
         CSR_HOME:   home_cfg = value[CHAN_FIELD_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Registers change only with the block idle and nothing owed.
   task automatic apply_settings(input logic [MS_W-1:0] settle, dwell,
                                 input logic [CHAN_FIELD_W-1:0] home);
      drain_results();
      write_register(CSR_SETTLE, settle);
      write_register(CSR_DWELL, dwell);
      write_register(CSR_HOME, {{(MS_W - CHAN_FIELD_W){1'b0}}, home});
   endtask

   // Idling patterns: a lazy receiver, then a lazy sender, then full speed.
   task automatic select_idling(input int pattern);
      case (pattern)
         0: begin
            sender_idle_pct = 11;
            receiver_stall_pct = 80;
         end
         1: begin
            sender_idle_pct = 80;
            receiver_stall_pct = 11;
         end
         default: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   // With the sweep stopped, ticks and frames change nothing, the unused
   // request codes only report, out-of-range queries read zeros, and a stop
   // still retunes the radio to the home channel.
   task automatic test_stopped_requests();
      send_request(REQ_QUERY, 32'h0000_0000, 4'd0);
      send_request(REQ_TICK, 32'hFFFF_FFFF, 4'd1);
      send_request(REQ_FRAME, 32'd1000, 4'd13);
      send_request(3'd5, 32'd0, 4'd14);
      send_request(3'd6, 32'hAAAA_5555, 4'd15);
      send_request(3'd7, 32'h5555_AAAA, 4'd7);
      send_request(REQ_STOP, 32'd50, 4'd6);
   endtask

   // A sweep at the default timing that starts just before the timestamp
   // wraps: frames inside the settling time are dropped, a tick one
   // millisecond short of the dwell does nothing, restart clears the tables.
   task automatic test_sweep_basics();
      logic [TIME_W-1:0] base;
      base = 32'hFFFF_FF80;
      send_request(REQ_START, base, 4'd1);
      send_request(REQ_FRAME, base + 32'd50, 4'd1);
      send_request(REQ_FRAME, base + 32'd100, 4'd1);
      send_request(REQ_FRAME, base + 32'd300, 4'd2);
      send_request(REQ_FRAME, base + 32'd499, 4'd1);
      send_request(REQ_TICK, base + 32'd499, 4'd1);
      send_request(REQ_TICK, base + 32'd500, 4'd1);
      send_request(REQ_FRAME, base + 32'd600, 4'd1);
      send_request(REQ_TICK, base + 32'd1000, 4'd2);
      send_request(REQ_QUERY, base + 32'd1001, 4'd1);
      send_request(REQ_START, base + 32'd1100, 4'd1);
      send_request(REQ_QUERY, base + 32'd1101, 4'd2);
      send_request(REQ_STOP, base + 32'd1200, 4'd1);
   endtask

   // Settle equal to dwell and settle above dwell both leave no capture
   // window. A full lap also shows that peak and last nonzero outlive a zero.
   task automatic test_empty_window();
      int k;
      apply_settings(16'd5, 16'd5, 4'd1);
      send_request(REQ_START, 32'd1000, 4'd1);
      send_request(REQ_FRAME, 32'd1005, 4'd1);
      send_request(REQ_TICK, 32'd1005, 4'd1);
      for (k = 1; k <= NUM_CHANNELS - 1; k++)
         send_request(REQ_TICK, 32'd1005 + 5 * k, 4'(k + 1));
      send_request(REQ_TICK, 32'd1070, 4'd1);
      apply_settings(16'd200, 16'd100, 4'd6);
      send_request(REQ_START, 32'd5000, 4'd1);
      send_request(REQ_FRAME, 32'd5150, 4'd1);
      send_request(REQ_TICK, 32'd5150, 4'd1);
      send_request(REQ_STOP, 32'd5160, 4'd1);
   endtask

   // Register extremes: the longest settle and dwell, and home channel
   // values outside the channel range that pass straight through.
   task automatic test_register_extremes();
      apply_settings(16'hFFFF, 16'hFFFF, 4'd0);
      send_request(REQ_START, 32'd10, 4'd1);
      send_request(REQ_FRAME, 32'd10 + 32'd65534, 4'd1);
      send_request(REQ_FRAME, 32'd10 + 32'd65535, 4'd1);
      send_request(REQ_TICK, 32'd10 + 32'd65535, 4'd1);
      send_request(REQ_STOP, 32'd70000, 4'd1);
      apply_settings(16'd0, 16'hFFFF, 4'd15);
      send_request(REQ_STOP, 32'd70001, 4'd15);
      apply_settings(16'd0, 16'd1, 4'd13);
      send_request(REQ_STOP, 32'd70002, 4'd13);
   endtask

   // A one millisecond window drives the rate past full scale.
   task automatic test_saturation();
      int k;
      apply_settings(16'd0, 16'd1, 4'd6);
      send_request(REQ_START, 32'd0, 4'd1);
      for (k = 0; k < 70; k++)
         send_request(REQ_FRAME, 32'd0, 4'd1);
      send_request(REQ_TICK, 32'd1, 4'd1);
   endtask

   // Random sweeps. Each stretch picks new timing, mostly starts a sweep and
   // then walks the timestamp forward in steps scaled to the dwell time so
   // that frames land on both sides of the settling edge and ticks commit.
   // Occasional large jumps, stops, restarts and stray codes add noise.
   task automatic test_random_sweeps(input int item_budget);
      logic [MS_W-1:0]         settle, dwell;
      logic [CHAN_FIELD_W-1:0] home, chan;
      logic [REQ_W-1:0]        kind;
      logic [TIME_W-1:0]       stamp;
      int                      sent, stretch, span, pick, stretch_len;
      sent = 0;
      stretch = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(0, 99);
         if (stretch == 0) begin
            settle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            dwell = $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
         end else if (pick < 60) begin
            settle = MS_W'($urandom_range(0, 40));
            dwell = settle + MS_W'($urandom_range(1, 80));
         end else if (pick < 75) begin
            settle = MS_W'($urandom_range(1, 60));
            dwell = MS_W'($urandom_range(1, settle));
         end else begin
            settle = MS_W'($urandom());
            dwell = MS_W'($urandom_range(1, 65535));
         end
         home = CHAN_FIELD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 13));
         apply_settings(settle, dwell, home);
         span = ((settle > dwell) ? settle : dwell) / 6 + 2;
         stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * span)
                                             : $urandom();
         if ($urandom_range(0, 9) != 0) begin
            send_request(REQ_START, stamp, 4'd1);
            sent++;
         end
         stretch_len = $urandom_range(40, 90);
         repeat (stretch_len) begin
            stamp += ($urandom_range(0, 29) == 0) ? $urandom() : $urandom_range(0, span);
            pick = $urandom_range(0, 99);
            if (pick < 55)      kind = REQ_FRAME;
            else if (pick < 82) kind = REQ_TICK;
            else if (pick < 88) kind = REQ_W'($urandom_range(REQ_QUERY, 7));
            else if (pick < 91) kind = REQ_STOP;
            else if (pick < 94) kind = REQ_START;
            else                kind = REQ_W'($urandom_range(0, 7));
            chan = CHAN_FIELD_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 13));
            send_request(kind, stamp, chan);
            sent++;
         end
         stretch++;
      end
   endtask

   // The receiver decides at each falling edge whether it will take a result.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // Each result transaction is checked against the oldest owed report.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result transaction arrived with nothing owed");
         end else begin
            due_report = expected_reports.pop_front();
            compare_field("current_channel", RATE_W'(rsp_current_channel),
                          RATE_W'(due_report.current_channel));
            compare_field("sweep_running", RATE_W'(rsp_sweep_running),
                          RATE_W'(due_report.sweep_running));
            compare_field("settling", RATE_W'(rsp_settling),
                          RATE_W'(due_report.settling));
            compare_field("tune_valid", RATE_W'(rsp_tune_valid),
                          RATE_W'(due_report.tune_valid));
            compare_field("tune_channel", RATE_W'(rsp_tune_channel),
                          RATE_W'(due_report.tune_channel));
            compare_field("query_rate", rsp_query_rate, due_report.query_rate);
            compare_field("query_peak", rsp_query_peak, due_report.query_peak);
            compare_field("query_last_nonzero", rsp_query_last_nonzero,
                          due_report.query_last_nonzero);
            reports_checked++;
         end
      end
   end

   // Main sequence: one reset, the directed tests, then random sweeps under
   // each idling pattern, and the verdict once nothing is owed.
   initial begin
      req_valid = 1'b0;
      req_type = REQ_TICK;
      req_now_ms = '0;
      req_query_channel = '0;
      csr_we = 1'b0;
      csr_index = CSR_SETTLE;
      csr_wdata = '0;
      foreach (rate_log[i]) begin
         rate_log[i] = '0;
         peak_log[i] = '0;
         nonzero_log[i] = '0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      select_idling(0);
      test_stopped_requests();
      test_sweep_basics();
      test_empty_window();
      test_register_extremes();
      test_saturation();
      test_random_sweeps(200);
      select_idling(1);
      test_random_sweeps(200);
      select_idling(2);
      test_random_sweeps(200);

      drain_results();
      if (expected_reports.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
      $display("%0d request transactions, %0d results checked, %0d channel commits",
               requests_sent, reports_checked, rates_committed);
      $display("stopped requests, wrap, empty window, saturation, random sweeps; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS channel_sweep_frame_rate_monitor");
      end else begin
         $display("FAIL channel_sweep_frame_rate_monitor");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(WATCHDOG_UNITS);
      $display("timed out with %0d results still owed", expected_reports.size());
      $display("FAIL channel_sweep_frame_rate_monitor");
      $finish;
   end

endmodule
